// ===== hw/rtl/gbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared widths, register indexes and reset values of the 5x5 blur block.
// ----------------------------------------------------------------------------
package gbr_pkg;

   localparam int ROWS_KEPT  = 8;
   localparam int ROW_SEL_W  = 3;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int COEF_W     = 16;
   localparam int GWT_W      = 32;   // product of two Q0.16 coefficients
   localparam int RWT_W      = 11;   // range weight, up to 5 * 255
   localparam int PROD_W     = CH_W + GWT_W;
   localparam int ACC_W      = 46;
   localparam int NUM_W      = 24;   // range numerator, 25 * 255 * 1275 max
   localparam int DEN_W      = 15;   // range weight sum, 25 * 1275 max
   localparam int GAUSS_SHIFT = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SIZE_W     = 11;
   localparam int THR_W      = 8;

   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FAR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd7;

   localparam logic [THR_W-1:0]  RST_THRESH = 8'd50;
   localparam logic [COEF_W-1:0] RST_CENTER = 16'd32711;
   localparam logic [COEF_W-1:0] RST_NEAR   = 16'd14976;
   localparam logic [COEF_W-1:0] RST_FAR    = 16'd1437;
   localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd640;
   localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;
   localparam logic [SIZE_W-1:0] MIN_SIZE   = 11'd3;
   localparam logic [THR_W-1:0]  MIN_THRESH = 8'd2;

   localparam logic [2:0] TAP_MID  = 3'd2;
   localparam logic [2:0] TAP_LAST = 3'd4;

   localparam logic KIND_PIXEL = 1'b0;

   // 1D kernel tap: far, near, center, near, far
   function automatic logic [COEF_W-1:0] coef_pick(input logic [2:0] idx,
                                                   input logic [COEF_W-1:0] cen,
                                                   input logic [COEF_W-1:0] near,
                                                   input logic [COEF_W-1:0] far);
      logic [COEF_W-1:0] k;
      if (idx == TAP_MID) begin
         k = cen;
      end else if (idx == 3'd1 || idx == 3'd3) begin
         k = near;
      end else begin
         k = far;
      end
      return k;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gaussian_range_blur_5x5.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_range_blur_5x5
// 5x5 gaussian / range-weighted smoothing on a raster stream, reflect-101
// borders, line store of eight rows in one RAM.
// ----------------------------------------------------------------------------
// An item without a result passes the update, position and compare states and
// returns to idle. An item with a result then makes 26 reads (centre plus 25
// taps) through the single RAM read port and drains the pipeline in gaussian
// mode; range mode adds the 1-bit/cycle divider.
// Throughput: one transaction in flight; a finished result may wait at the
// output register while the next transaction is taken. Reset: counters cleared.
// ----------------------------------------------------------------------------
module gaussian_range_blur_5x5 import gbr_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CH_W-1:0]       req_chan_a,
   input  logic [CH_W-1:0]       req_chan_b,
   input  logic [CH_W-1:0]       req_chan_c,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CH_W-1:0]       rsp_out_a,
   output logic [CH_W-1:0]       rsp_out_b,
   output logic [CH_W-1:0]       rsp_out_c,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int AW    = ROW_SEL_W + CW;
   localparam int DEPTH = ROWS_KEPT * (2 ** CW);
   localparam int PW    = RW + WW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_UPD, S_MUL, S_CMP, S_RD, S_DRAIN, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic              csr_mode_ff;
   logic              csr_color_ff;
   logic [THR_W-1:0]  csr_thr_ff;
   logic [COEF_W-1:0] csr_center_ff;
   logic [COEF_W-1:0] csr_near_ff;
   logic [COEF_W-1:0] csr_far_ff;
   logic [SIZE_W-1:0] csr_width_ff;
   logic [SIZE_W-1:0] csr_height_ff;

   logic [WW-1:0] w_lim;
   logic [RW-1:0] h_lim;
   logic [THR_W-1:0] thr;

   // counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [WW-1:0] col_next;
   logic          last_in;

   // captured transaction
   logic            item_kind_ff;
   logic [PIX_W-1:0] item_pix_ff;

   // line store
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   logic [PIX_W-1:0] ram_rdata;

   // emit decision
   logic [PW-1:0] pos_in_ff;
   logic [PW-1:0] pos_out_ff;
   logic          done_ff;
   logic          emit;

   // tap sequencer and pipeline
   logic                first_ff;
   logic [2:0]          ty_ff;
   logic [2:0]          tx_ff;
   logic [2:0]          sel_ty;
   logic [2:0]          sel_tx;
   logic                issue;
   logic signed [RW+1:0] ri;
   logic signed [WW+1:0] ci;
   logic [GWT_W-1:0]    wt1_ff;
   logic                c1_ff, v1_ff, v2_ff, v3_ff;
   logic                pipe_empty;
   logic [CH_W-1:0]     p0_ff;
   logic [CH_W-1:0]     p1;
   logic [CH_W-1:0]     dif;
   logic [RWT_W-1:0]    t5;
   logic [RWT_W-1:0]    d2;
   logic [RWT_W-1:0]    rwt;
   logic [CH_W-1:0]     op_p_ff [NUM_CH];
   logic [GWT_W-1:0]    op_w_ff;
   logic [PROD_W-1:0]   prod_ff [NUM_CH];
   logic [RWT_W-1:0]    pw_ff;
   logic [ACC_W-1:0]    acc_ff [NUM_CH];
   logic [DEN_W-1:0]    den_ff;

   // divider and results
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;
   logic [CH_W-1:0]  res_ff [NUM_CH];
   logic             out_free;
   logic             out_step;

   logic             rsp_valid_ff;
   logic [CH_W-1:0]  rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic             rsp_last_ff;

   function automatic logic [CH_W-1:0] gsat(input logic [ACC_W-1:0] a);
      logic [CH_W-1:0] r;
      if (|a[ACC_W-1:GAUSS_SHIFT+CH_W]) begin
         r = '1;
      end else begin
         r = a[GAUSS_SHIFT +: CH_W];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------ limits
   always_comb begin
      if (csr_width_ff < MIN_SIZE) begin
         w_lim = WW'(MIN_SIZE);
      end else if (32'(csr_width_ff) > 32'(MAX_WIDTH)) begin
         w_lim = WW'(MAX_WIDTH);
      end else begin
         w_lim = WW'(csr_width_ff);
      end
      if (csr_height_ff < MIN_SIZE) begin
         h_lim = RW'(MIN_SIZE);
      end else if (32'(csr_height_ff) > 32'(MAX_HEIGHT)) begin
         h_lim = RW'(MAX_HEIGHT);
      end else begin
         h_lim = RW'(csr_height_ff);
      end
      thr = (csr_thr_ff < MIN_THRESH) ? MIN_THRESH : csr_thr_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_step  = (state_ff == S_OUT) && out_free;

   // ------------------------------------------------------- counter updates
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      col_next   = '0;
      last_in    = 1'b0;
      if (state_ff == S_UPD) begin
         if (out_row_in >= h_lim) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
         if (WW'(in_col_in) >= w_lim) begin
            in_col_in = '0;
            in_row_in = in_row_in + RW'(1);
         end
         if (WW'(out_col_in) >= w_lim) begin
            out_col_in = '0;
            out_row_in = out_row_in + RW'(1);
            if (out_row_in >= h_lim) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
         if (item_kind_ff == KIND_PIXEL && in_row_in < h_lim) begin
            ram_we    = 1'b1;
            ram_waddr = {in_row_in[ROW_SEL_W-1:0], in_col_in};
            col_next  = WW'(in_col_in) + WW'(1);
            if (col_next >= w_lim) begin
               in_col_in = '0;
               in_row_in = in_row_in + RW'(1);
            end else begin
               in_col_in = CW'(col_next);
            end
         end
      end else if (out_step) begin
         col_next = WW'(out_col_ff) + WW'(1);
         if (col_next >= w_lim) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RW'(1);
            if (out_row_in >= h_lim) begin
               last_in    = 1'b1;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end else begin
            out_col_in = CW'(col_next);
         end
      end
   end

   assign emit = done_ff || (pos_in_ff >= pos_out_ff);

   // ----------------------------------------------- tap address, reflect-101
   assign issue  = (state_ff == S_RD);
   assign sel_ty = first_ff ? TAP_MID : ty_ff;
   assign sel_tx = first_ff ? TAP_MID : tx_ff;

   always_comb begin
      ri = $signed((RW+2)'(out_row_ff)) + $signed((RW+2)'(sel_ty))
           - $signed((RW+2)'(2));
      if (ri < 0) begin
         ri = -ri;
      end
      if (ri >= $signed((RW+2)'(h_lim))) begin
         ri = $signed((RW+2)'(h_lim) << 1) - $signed((RW+2)'(2)) - ri;
      end
      ci = $signed((WW+2)'(out_col_ff)) + $signed((WW+2)'(sel_tx))
           - $signed((WW+2)'(2));
      if (ci < 0) begin
         ci = -ci;
      end
      if (ci >= $signed((WW+2)'(w_lim))) begin
         ci = $signed((WW+2)'(w_lim) << 1) - $signed((WW+2)'(2)) - ci;
      end
      ram_raddr = {ri[ROW_SEL_W-1:0], ci[CW-1:0]};
   end

   // range weight from the returning read
   always_comb begin
      p1  = ram_rdata[CH_W-1:0];
      dif = (p1 > p0_ff) ? p1 - p0_ff : p0_ff - p1;
      t5  = (RWT_W'(thr) << 2) + RWT_W'(thr);
      d2  = RWT_W'(dif) << 1;
      rwt = (t5 > d2) ? t5 - d2 : '0;
   end

   assign pipe_empty = !c1_ff && !v1_ff && !v2_ff && !v3_ff;
   assign div_start  = (state_ff == S_DRAIN) && pipe_empty && csr_mode_ff;

   gbr_ram #(
      .WIDTH(PIX_W),
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_pix_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   gbr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff[0][NUM_W-1:0]),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ----------------------------------------------------- control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_mode_ff   <= 1'b0;
         csr_color_ff  <= 1'b0;
         csr_thr_ff    <= RST_THRESH;
         csr_center_ff <= RST_CENTER;
         csr_near_ff   <= RST_NEAR;
         csr_far_ff    <= RST_FAR;
         csr_width_ff  <= RST_WIDTH;
         csr_height_ff <= RST_HEIGHT;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         first_ff      <= 1'b0;
         ty_ff         <= '0;
         tx_ff         <= '0;
         c1_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_MODE:   csr_mode_ff   <= csr_wdata[0];
               REG_COLOR:  csr_color_ff  <= csr_wdata[0];
               REG_THRESH: csr_thr_ff    <= csr_wdata[THR_W-1:0];
               REG_CENTER: csr_center_ff <= csr_wdata;
               REG_NEAR:   csr_near_ff   <= csr_wdata;
               REG_FAR:    csr_far_ff    <= csr_wdata;
               REG_WIDTH:  csr_width_ff  <= csr_wdata[SIZE_W-1:0];
               REG_HEIGHT: csr_height_ff <= csr_wdata[SIZE_W-1:0];
               default:    csr_mode_ff   <= csr_mode_ff;
            endcase
         end

         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;

         c1_ff <= issue && first_ff;
         v1_ff <= issue && !first_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_step) begin
            rsp_valid_ff <= 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: state_ff <= S_MUL;
            S_MUL: state_ff <= S_CMP;
            S_CMP: begin
               if (emit) begin
                  state_ff <= S_RD;
                  first_ff <= 1'b1;
                  ty_ff    <= '0;
                  tx_ff    <= '0;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_RD: begin
               if (first_ff) begin
                  first_ff <= 1'b0;
               end else if (tx_ff == TAP_LAST) begin
                  tx_ff <= '0;
                  if (ty_ff == TAP_LAST) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     ty_ff <= ty_ff + 3'd1;
                  end
               end else begin
                  tx_ff <= tx_ff + 3'd1;
               end
            end
            S_DRAIN: begin
               if (pipe_empty) begin
                  state_ff <= csr_mode_ff ? S_DIV : S_OUT;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // --------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_kind_ff <= req_kind;
         item_pix_ff  <= {req_chan_c, req_chan_b, req_chan_a};
      end

      if (state_ff == S_MUL) begin
         pos_in_ff  <= PW'(in_row_ff) * PW'(w_lim) + PW'(in_col_ff);
         pos_out_ff <= PW'(out_row_ff) * PW'(w_lim) + PW'(out_col_ff)
                       + (PW'(w_lim) << 1) + PW'(3);
         done_ff    <= in_row_ff >= h_lim;
      end

      wt1_ff <= GWT_W'(coef_pick(sel_ty, csr_center_ff, csr_near_ff, csr_far_ff))
              * GWT_W'(coef_pick(sel_tx, csr_center_ff, csr_near_ff, csr_far_ff));

      if (c1_ff) begin
         p0_ff <= p1;
      end

      for (int ch = 0; ch < NUM_CH; ch++) begin
         op_p_ff[ch] <= ram_rdata[ch*CH_W +: CH_W];
         prod_ff[ch] <= PROD_W'(op_p_ff[ch]) * PROD_W'(op_w_ff);
      end
      op_w_ff <= csr_mode_ff ? GWT_W'(rwt) : wt1_ff;
      pw_ff   <= op_w_ff[RWT_W-1:0];

      if (state_ff == S_CMP) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            acc_ff[ch] <= '0;
         end
         den_ff <= '0;
      end else if (v3_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod_ff[ch]);
         end
         den_ff <= den_ff + DEN_W'(pw_ff);
      end

      if (state_ff == S_DRAIN && pipe_empty && !csr_mode_ff) begin
         res_ff[0] <= gsat(acc_ff[0]);
         res_ff[1] <= csr_color_ff ? gsat(acc_ff[1]) : '0;
         res_ff[2] <= csr_color_ff ? gsat(acc_ff[2]) : '0;
      end else if (state_ff == S_DIV && div_done) begin
         res_ff[0] <= (|div_quo[NUM_W-1:CH_W]) ? '1 : div_quo[CH_W-1:0];
         res_ff[1] <= '0;
         res_ff[2] <= '0;
      end

      if (out_step) begin
         rsp_a_ff    <= res_ff[0];
         rsp_b_ff    <= res_ff[1];
         rsp_c_ff    <= res_ff[2];
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_a         = rsp_a_ff;
   assign rsp_out_b         = rsp_b_ff;
   assign rsp_out_c         = rsp_c_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // ------------------------------------------------------------- assertions
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> den_ff != '0)
      else $error("range weight sum is zero at divide start");

   a_window_in_frame: assert property (@(posedge clock) disable iff (reset)
      issue |-> (out_row_ff < h_lim) && (WW'(out_col_ff) < w_lim))
      else $error("window centre outside the frame");

   a_frame_end_clear: assert property (@(posedge clock) disable iff (reset)
      (out_step && last_in) |=> (in_row_ff == '0) && (out_row_ff == '0))
      else $error("counters not cleared after the last result of a frame");

endmodule
`default_nettype wire

// ===== hw/rtl/gbr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/gbr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_div
// Restoring divider, one quotient bit per cycle, for the range-mode average.
// ----------------------------------------------------------------------------
module gbr_div import gbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         num_ff <= num_ff << 1;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire
